/* sv/assert_macros.svh */
// assertion macros shared by the motor feedback and command engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check of a property at every rising clock edge outside reset
`define CMFB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define CMFB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/cmfb_pkg.sv */
// types, codes and constants of the motor feedback and command engine
`timescale 1ns / 1ps

package cmfb_pkg;

   localparam int DEF_NUM_SLOTS   = 8;
   localparam int DEF_ACCUM_WIDTH = 32;

   localparam logic [1:0] MODE_FEEDBACK = 2'd0;
   localparam logic [1:0] MODE_SET      = 2'd1;
   localparam logic [1:0] MODE_PUSH     = 2'd2;

   localparam logic KIND_FEEDBACK = 1'b0;
   localparam logic KIND_COMMAND  = 1'b1;

   localparam logic CSR_MOTOR_TYPE = 1'b0;
   localparam logic CSR_SLOT_MASK  = 1'b1;

   localparam logic [10:0] RX_BASE_CURRENT = 11'h201;
   localparam logic [10:0] RX_BASE_VOLTAGE = 11'h205;
   localparam logic [10:0] TX_ID_200       = 11'h200;
   localparam logic [10:0] TX_ID_1FF       = 11'h1FF;
   localparam logic [10:0] TX_ID_2FF       = 11'h2FF;

   localparam logic signed [15:0] CMD_LIMIT_CURRENT = 16'sd16384;
   localparam logic signed [15:0] CMD_LIMIT_VOLTAGE = 16'sd25000;

   localparam logic signed [17:0] HALF_TURN = 18'sd4096;
   localparam logic signed [17:0] FULL_TURN = 18'sd8192;

   typedef struct packed {
      logic [1:0]         mode;
      logic [10:0]        frame_id;
      logic [63:0]        frame_payload;
      logic [2:0]         slot;
      logic signed [15:0] command_value;
   } req_word_type;

   typedef struct packed {
      logic               kind;
      logic [2:0]         motor_slot;
      logic [15:0]        raw_angle;
      logic signed [15:0] rotor_speed;
      logic signed [15:0] phase_current;
      logic [7:0]         temperature;
      logic signed [31:0] total_angle;
      logic [10:0]        tx_id;
      logic [63:0]        tx_payload;
      logic               last;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FB_DELTA,
      ST_FB_COMMIT,
      ST_PUSH
   } ctrl_state_type;

   typedef struct packed {
      logic       load;
      logic       set_cmd;
      logic       fb_delta;
      logic       fb_commit;
      logic       push_step;
      logic [2:0] scan;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       fb_hit;
   } dp_status_type;

endpackage

/* sv/cmfb_ctrl.sv */
// sequencer: decodes the latched word and steps the datapath through it
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmfb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  cmfb_pkg::dp_status_type status,
   output cmfb_pkg::dp_cmd_type    cmd
);

   cmfb_pkg::ctrl_state_type state_ff, state_in;
   logic [2:0] scan_ff, scan_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmfb_pkg::ST_IDLE;
         scan_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      cmd           = '0;
      cmd.scan      = scan_ff;
      busy          = (state_ff != cmfb_pkg::ST_IDLE);
      unique case (state_ff)
         cmfb_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = cmfb_pkg::ST_DECODE;
            end
         end
         cmfb_pkg::ST_DECODE: begin
            scan_in = 3'd0;
            priority if (status.mode == cmfb_pkg::MODE_FEEDBACK && status.fb_hit) begin
               state_in = cmfb_pkg::ST_FB_DELTA;
            end else if (status.mode == cmfb_pkg::MODE_SET) begin
               cmd.set_cmd = 1'b1;
               state_in    = cmfb_pkg::ST_IDLE;
            end else if (status.mode == cmfb_pkg::MODE_PUSH) begin
               state_in = cmfb_pkg::ST_PUSH;
            end else begin
               state_in = cmfb_pkg::ST_IDLE;
            end
         end
         cmfb_pkg::ST_FB_DELTA: begin
            cmd.fb_delta = 1'b1;
            state_in     = cmfb_pkg::ST_FB_COMMIT;
         end
         cmfb_pkg::ST_FB_COMMIT: begin
            cmd.fb_commit = 1'b1;
            state_in      = cmfb_pkg::ST_IDLE;
         end
         cmfb_pkg::ST_PUSH: begin
            cmd.push_step = 1'b1;
            scan_in       = scan_ff + 3'd1;
            if (scan_ff == 3'd7) begin
               state_in = cmfb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cmfb_pkg::ST_IDLE;
         end
      endcase
   end

   `CMFB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted word did not raise busy")
   `CMFB_ASSERT_NEXT(a_push_ends, clock, reset, state_ff == cmfb_pkg::ST_PUSH && scan_ff == 3'd7, !busy, "slot walk did not end after the last slot")

endmodule

/* sv/cmfb_datapath.sv */
// per-slot state, angle unwrap, command clamp and frame assembly
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmfb_datapath #(
   parameter int NUM_SLOTS   = cmfb_pkg::DEF_NUM_SLOTS,
   parameter int ACCUM_WIDTH = cmfb_pkg::DEF_ACCUM_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmfb_pkg::req_word_type  req_data,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [7:0]             csr_wdata,
   input  cmfb_pkg::dp_cmd_type    cmd,
   output cmfb_pkg::dp_status_type status,
   output logic                   rsp_strobe,
   output cmfb_pkg::rsp_word_type  rsp_data
);

   localparam int SIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int WW  = (ACCUM_WIDTH > 32) ? ACCUM_WIDTH : 32;
   localparam logic [3:0] NS4 = 4'(NUM_SLOTS);
   localparam logic signed [ACCUM_WIDTH:0] ACC_MAX = {2'b00, {(ACCUM_WIDTH-1){1'b1}}};
   localparam logic signed [ACCUM_WIDTH:0] ACC_MIN = {2'b11, {(ACCUM_WIDTH-1){1'b0}}};
   localparam logic signed [WW-1:0] REP_MAX = WW'(32'sh7fff_ffff);
   localparam logic signed [WW-1:0] REP_MIN = WW'(32'sh8000_0000);

   // configuration
   logic       mtype_ff;
   logic [7:0] mask_ff;

   // latched request and working registers
   cmfb_pkg::req_word_type req_ff;
   logic signed [17:0]     delta_ff, delta_in;
   logic [63:0]            frame_ff, frame_in;
   logic                   strobe_ff, strobe_in;
   cmfb_pkg::rsp_word_type rsp_ff, rsp_in;

   // per-slot state
   logic [15:0]                   prev_ff [NUM_SLOTS];
   logic signed [ACCUM_WIDTH-1:0] acc_ff  [NUM_SLOTS];
   logic signed [15:0]            cmd_ff  [NUM_SLOTS];

   logic [7:0]                    eff_mask;
   logic [10:0]                   rx_base;
   logic [10:0]                   id_off;
   logic [2:0]                    fb_slot;
   logic [SIW-1:0]                fb_idx;
   logic [SIW-1:0]                scan_idx;
   logic [SIW-1:0]                set_idx;
   logic                          set_ok;
   logic [15:0]                   prev_rd;
   logic signed [ACCUM_WIDTH-1:0] acc_rd;
   logic signed [15:0]            cmd_rd;
   logic signed [17:0]            diff;
   logic signed [ACCUM_WIDTH:0]   acc_sum;
   logic signed [ACCUM_WIDTH-1:0] acc_sat;
   logic signed [WW-1:0]          acc_wide;
   logic signed [WW-1:0]          rep_wide;
   logic signed [15:0]            cmd_lim;
   logic signed [15:0]            cmd_clamped;
   logic [63:0]                   contrib;
   logic [1:0]                    pos;
   logic                          half;
   logic                          used_lo;
   logic                          used_hi;
   logic                          half_used;

   // slots usable under the present motor type and slot count
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         eff_mask[i] = mask_ff[i] && (4'(i) < NS4) && !(mtype_ff && i == 7);
      end
   end

   assign used_lo = |eff_mask[3:0];
   assign used_hi = |eff_mask[7:4];

   // receive window
   assign rx_base = mtype_ff ? cmfb_pkg::RX_BASE_VOLTAGE : cmfb_pkg::RX_BASE_CURRENT;
   assign id_off  = req_ff.frame_id - rx_base;
   assign fb_slot = id_off[2:0];
   assign fb_idx  = fb_slot[SIW-1:0];

   assign status.mode   = req_ff.mode;
   assign status.fb_hit = (req_ff.frame_id >= rx_base) && (id_off < 11'd8)
                          && eff_mask[fb_slot];

   assign prev_rd = prev_ff[fb_idx];
   assign acc_rd  = acc_ff[fb_idx];

   // step between raw angles folded into one half turn either way
   always_comb begin
      diff = $signed({2'b00, req_ff.frame_payload[63:48]}) - $signed({2'b00, prev_rd});
      priority if (diff > cmfb_pkg::HALF_TURN) begin
         delta_in = diff - cmfb_pkg::FULL_TURN;
      end else if (diff < -cmfb_pkg::HALF_TURN) begin
         delta_in = diff + cmfb_pkg::FULL_TURN;
      end else begin
         delta_in = diff;
      end
   end

   // saturating accumulate, then report within 32 bits
   always_comb begin
      acc_sum = (ACCUM_WIDTH+1)'(acc_rd) + (ACCUM_WIDTH+1)'(delta_ff);
      priority if (acc_sum > ACC_MAX) begin
         acc_sat = ACC_MAX[ACCUM_WIDTH-1:0];
      end else if (acc_sum < ACC_MIN) begin
         acc_sat = ACC_MIN[ACCUM_WIDTH-1:0];
      end else begin
         acc_sat = acc_sum[ACCUM_WIDTH-1:0];
      end
      acc_wide = WW'(acc_sat);
      priority if (acc_wide > REP_MAX) begin
         rep_wide = REP_MAX;
      end else if (acc_wide < REP_MIN) begin
         rep_wide = REP_MIN;
      end else begin
         rep_wide = acc_wide;
      end
   end

   // command clamp by motor type
   always_comb begin
      cmd_lim = mtype_ff ? cmfb_pkg::CMD_LIMIT_VOLTAGE : cmfb_pkg::CMD_LIMIT_CURRENT;
      priority if (req_ff.command_value > cmd_lim) begin
         cmd_clamped = cmd_lim;
      end else if (req_ff.command_value < -cmd_lim) begin
         cmd_clamped = -cmd_lim;
      end else begin
         cmd_clamped = req_ff.command_value;
      end
   end

   assign set_ok  = ({1'b0, req_ff.slot} < NS4);
   assign set_idx = req_ff.slot[SIW-1:0];

   // slot walk for the command frames
   assign pos       = cmd.scan[1:0];
   assign half      = cmd.scan[2];
   assign scan_idx  = cmd.scan[SIW-1:0];
   assign half_used = half ? used_hi : used_lo;
   assign cmd_rd    = ({1'b0, cmd.scan} < NS4) ? cmd_ff[scan_idx] : 16'sd0;

   always_comb begin
      contrib = 64'd0;
      if (eff_mask[cmd.scan]) begin
         unique case (pos)
            2'd0:    contrib = {cmd_rd, 48'd0};
            2'd1:    contrib = {16'd0, cmd_rd, 32'd0};
            2'd2:    contrib = {32'd0, cmd_rd, 16'd0};
            default: contrib = {48'd0, cmd_rd};
         endcase
      end
   end

   always_comb begin
      frame_in  = frame_ff;
      strobe_in = 1'b0;
      rsp_in    = '0;
      if (cmd.load) begin
         frame_in = 64'd0;
      end
      if (cmd.fb_commit) begin
         strobe_in             = 1'b1;
         rsp_in.kind           = cmfb_pkg::KIND_FEEDBACK;
         rsp_in.motor_slot     = fb_slot;
         rsp_in.raw_angle      = req_ff.frame_payload[63:48];
         rsp_in.rotor_speed    = req_ff.frame_payload[47:32];
         rsp_in.phase_current  = req_ff.frame_payload[31:16];
         rsp_in.temperature    = req_ff.frame_payload[15:8];
         rsp_in.total_angle    = rep_wide[31:0];
         rsp_in.last           = 1'b1;
      end
      if (cmd.push_step) begin
         frame_in = frame_ff | contrib;
         if (pos == 2'd3) begin
            // end of a frame's four slots
            strobe_in         = half_used;
            rsp_in.kind       = cmfb_pkg::KIND_COMMAND;
            rsp_in.tx_payload = frame_ff | contrib;
            rsp_in.last       = half ? 1'b1 : !used_hi;
            if (half) begin
               rsp_in.tx_id = mtype_ff ? cmfb_pkg::TX_ID_2FF : cmfb_pkg::TX_ID_1FF;
            end else begin
               rsp_in.tx_id = mtype_ff ? cmfb_pkg::TX_ID_1FF : cmfb_pkg::TX_ID_200;
            end
            frame_in = 64'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtype_ff  <= 1'b0;
         mask_ff   <= 8'd0;
         strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            prev_ff[i] <= 16'd0;
            acc_ff[i]  <= '0;
            cmd_ff[i]  <= 16'sd0;
         end
      end else begin
         strobe_ff <= strobe_in;
         if (csr_we) begin
            if (csr_index == cmfb_pkg::CSR_MOTOR_TYPE) begin
               mtype_ff <= csr_wdata[0];
            end else begin
               mask_ff <= csr_wdata;
            end
         end
         if (cmd.fb_commit) begin
            prev_ff[fb_idx] <= req_ff.frame_payload[63:48];
            acc_ff[fb_idx]  <= acc_sat;
         end
         if (cmd.set_cmd && set_ok) begin
            cmd_ff[set_idx] <= cmd_clamped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      delta_ff <= delta_in;
      frame_ff <= frame_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `CMFB_ASSERT_NEXT(a_strobe_gap, clock, reset, strobe_ff, !strobe_ff, "two result words in adjacent cycles")
   `CMFB_ASSERT(a_fb_last, clock, reset, !(strobe_ff && rsp_ff.kind == cmfb_pkg::KIND_FEEDBACK) || rsp_ff.last, "feedback word not marked last")

endmodule

/* sv/can_motor_feedback_command_engine.sv */
// top level of the motor group feedback and command engine
`timescale 1ns / 1ps

// Serves up to eight motors on one CAN bus.
// Request side: drive req_data and raise start; the word is taken at a
// rising edge with start high and busy low. Mode feedback decodes a
// received frame, mode set stores a clamped command for a slot, mode push
// emits the command frames of all enabled slots.
// Result side: rsp_data is valid for exactly one cycle while rsp_strobe is
// high; the receiver cannot stall, so words are never held back.
// Sequence after a word is taken:
//   feedback hit: the angle step is registered, then the result word is
//   registered and shown on the ports
//   feedback miss, set or unused mode: no result
//   push: slots are walked one per cycle through the single read port of
//     the command store; the low frame comes before the high frame; a new
//     word is taken only once busy is low again
// Configuration: csr_we writes csr_wdata into register csr_index
// (0 motor type, 1 slot enable mask) at once; write it only while idle.
// Reset (synchronous, active high) clears motor type, slot mask, sequencer,
// strobe, the per-slot angle history, unwrapped counts and stored commands.
module can_motor_feedback_command_engine #(
   parameter int NUM_SLOTS   = cmfb_pkg::DEF_NUM_SLOTS,
   parameter int ACCUM_WIDTH = cmfb_pkg::DEF_ACCUM_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  cmfb_pkg::req_word_type req_data,
   output logic                  rsp_strobe,
   output cmfb_pkg::rsp_word_type rsp_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata
);

   cmfb_pkg::dp_cmd_type    cmd;
   cmfb_pkg::dp_status_type status;

   cmfb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   cmfb_datapath #(
      .NUM_SLOTS   (NUM_SLOTS),
      .ACCUM_WIDTH (ACCUM_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
